// ----- rtl/core/ath_pkg.sv -----
// ----------------------------------------------------------------------------
// ath_pkg
// shared types, codes and constants of the averaging thermostat
// ----------------------------------------------------------------------------
package ath_pkg;

    // event codes on func
    localparam logic [2:0] FN_SAMPLE  = 3'd0;
    localparam logic [2:0] FN_CONTROL = 3'd1;
    localparam logic [2:0] FN_DOWN    = 3'd2;
    localparam logic [2:0] FN_UP      = 3'd3;
    localparam logic [2:0] FN_MS_TICK = 3'd4;
    localparam logic [2:0] FN_RESTORE = 3'd5;

    // register indexes
    localparam logic [1:0] REG_BAND    = 2'd0;
    localparam logic [1:0] REG_MIN_SP  = 2'd1;
    localparam logic [1:0] REG_MAX_SP  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [5:0]  BAND_RST    = 6'd5;
    localparam logic [7:0]  MIN_SP_RST  = 8'd35;
    localparam logic [7:0]  MAX_SP_RST  = 8'd75;
    localparam logic [15:0] TIMEOUT_RST = 16'd5000;
    localparam logic [7:0]  SETPOINT_RST = 8'd60;

    localparam int SAMPLES   = 10;
    localparam int ADC_BITS  = 10;
    localparam int VALUE_W   = 10;
    localparam int SUM_W     = 16;
    localparam int SP_W      = 8;
    localparam int BLINK_W   = 11;

    localparam int SCALE_NUM = 150;
    localparam int SCALE_DEN = 307;
    localparam int BLINK_MS  = 1000;
    localparam int STEP      = 5;

    // reading width actually used from value
    localparam int RD_W  = (ADC_BITS < VALUE_W) ? ADC_BITS : VALUE_W;
    // scaled reading is below half the reading
    localparam int DEG_W = RD_W - 1;

    // reading * 150 / 307 as a multiply by a rounded-up reciprocal
    localparam int SCALE_K = RD_W + 9;
    localparam int SCALE_M = (SCALE_NUM * (2 ** SCALE_K) + SCALE_DEN - 1) / SCALE_DEN;

    // sum / SAMPLES the same way
    localparam int AVG_K = SUM_W + $clog2(SAMPLES);
    localparam int AVG_M = ((2 ** AVG_K) + SAMPLES - 1) / SAMPLES;

    typedef struct packed {
        logic [5:0]  band;
        logic [7:0]  min_sp;
        logic [7:0]  max_sp;
        logic [15:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic             heater_on;
        logic             cooler_on;
        logic             led_on;
        logic             setting_active;
        logic             display_on;
        logic [SP_W-1:0]  setpoint;
        logic             save_strobe;
        logic [SUM_W-1:0] average;
    } res_t;

endpackage

// ----- rtl/core/averaging_thermostat_with_setpoint_entry.sv -----
// ----------------------------------------------------------------------------
// averaging_thermostat_with_setpoint_entry
// averaging bang-bang thermostat with hysteresis and button setpoint entry
// ----------------------------------------------------------------------------
// usage:
//   input beats (func, value) carry samples, control ticks, up/down presses,
//   millisecond ticks and setpoint restores; each beat yields exactly one
//   output beat with drive states, mode flags, setpoint and last average
//   the beat is held in the input register, then the single-pass update
//   loads the result register once the result slot is free
//   throughput: one beat per cycle while the output does not stall
//   the input side keeps accepting while a result waits, until both the
//   input register and the result register are full; a stalled output
//   holds its beat and backs pressure onto in_ready
//   apb writes set band, setpoint limits and entry timeout; write them only
//   while the block is idle; pready is tied high
//   reset empties both pipeline registers, loads setpoint 60 and the
//   register defaults; no clearing pass, the block is ready right away
// ----------------------------------------------------------------------------
module averaging_thermostat_with_setpoint_entry
(
    input  logic                        clk,
    input  logic                        rst_n,

    // apb config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ath_pkg::ADDR_W-1:0]  paddr,
    input  logic [ath_pkg::DATA_W-1:0]  pwdata,
    output logic [ath_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,

    // input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [2:0]                  func,
    input  logic [ath_pkg::VALUE_W-1:0] value,

    // output channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        heater_on,
    output logic                        cooler_on,
    output logic                        led_on,
    output logic                        setting_active,
    output logic                        display_on,
    output logic [ath_pkg::SP_W-1:0]    setpoint_out,
    output logic                        save_strobe,
    output logic [ath_pkg::SUM_W-1:0]   average_out
);
    import ath_pkg::*;

    cfg_t               cfg;
    res_t               res;

    // input register
    logic               in_valid_reg, in_valid_next;
    logic [2:0]         func_reg;
    logic [VALUE_W-1:0] value_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    res_t               res_reg;

    logic               advance;
    logic               fire;
    logic               in_take;

    // result slot free or being emptied this cycle
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    ath_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state update happens only when the beat moves into the result register
    ath_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (fire),
        .func  (func_reg),
        .value (value_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_comb
    begin
        priority if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb
    begin
        priority if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg  <= func;
            value_reg <= value;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign heater_on      = res_reg.heater_on;
    assign cooler_on      = res_reg.cooler_on;
    assign led_on         = res_reg.led_on;
    assign setting_active = res_reg.setting_active;
    assign display_on     = res_reg.display_on;
    assign setpoint_out   = res_reg.setpoint;
    assign save_strobe    = res_reg.save_strobe;
    assign average_out    = res_reg.average;

`ifndef SYNTHESIS
    // a held input beat with a free result slot must move on
    a_input_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("input beat not forwarded");

    // a result beat is never dropped while the receiver stalls
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !fire)
        else $error("result overwritten under stall");

    // with both stages full and a stall, nothing is taken in
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken with pipeline full");
`endif

endmodule

// ----- rtl/core/ath_cfg.sv -----
// ----------------------------------------------------------------------------
// ath_cfg
// apb register file for band, setpoint limits and entry timeout
// ----------------------------------------------------------------------------
module ath_cfg
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ath_pkg::ADDR_W-1:0] paddr,
    input  logic [ath_pkg::DATA_W-1:0] pwdata,
    output logic [ath_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output ath_pkg::cfg_t              cfg
);
    import ath_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_BAND:    cfg_next.band    = pwdata[5:0];
                REG_MIN_SP:  cfg_next.min_sp  = pwdata[7:0];
                REG_MAX_SP:  cfg_next.max_sp  = pwdata[7:0];
                REG_TIMEOUT: cfg_next.timeout = pwdata[15:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_BAND:    prdata = {{(DATA_W-6){1'b0}}, cfg_reg.band};
            REG_MIN_SP:  prdata = {{(DATA_W-8){1'b0}}, cfg_reg.min_sp};
            REG_MAX_SP:  prdata = {{(DATA_W-8){1'b0}}, cfg_reg.max_sp};
            REG_TIMEOUT: prdata = {{(DATA_W-16){1'b0}}, cfg_reg.timeout};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band    <= BAND_RST;
            cfg_reg.min_sp  <= MIN_SP_RST;
            cfg_reg.max_sp  <= MAX_SP_RST;
            cfg_reg.timeout <= TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/core/ath_arith.sv -----
// ----------------------------------------------------------------------------
// ath_arith
// reading to degrees scaling and accumulator averaging
// ----------------------------------------------------------------------------
module ath_arith
(
    input  logic [ath_pkg::RD_W-1:0]  reading,
    input  logic [ath_pkg::SUM_W-1:0] sum,
    output logic [ath_pkg::DEG_W-1:0] deg,
    output logic [ath_pkg::SUM_W-1:0] avg
);
    import ath_pkg::*;

    localparam int SP_PW = SCALE_K + DEG_W;
    localparam int AV_PW = AVG_K + SUM_W;

    logic [SP_PW-1:0] scale_prod;
    logic [AV_PW-1:0] avg_prod;

    // reciprocal is rounded up, error stays below one part in 307
    assign scale_prod = SP_PW'(reading) * SP_PW'(SCALE_M);
    assign deg        = scale_prod[SCALE_K +: DEG_W];

    assign avg_prod = AV_PW'(sum) * AV_PW'(AVG_M);
    assign avg      = avg_prod[AVG_K +: SUM_W];

endmodule

// ----- rtl/core/ath_ctrl.sv -----
// ----------------------------------------------------------------------------
// ath_ctrl
// thermostat state, hysteresis decision and setpoint entry mode
// ----------------------------------------------------------------------------
module ath_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        upd,
    input  logic [2:0]                  func,
    input  logic [ath_pkg::VALUE_W-1:0] value,
    input  ath_pkg::cfg_t               cfg,
    output ath_pkg::res_t               res
);
    import ath_pkg::*;

    logic [SP_W-1:0]    setpoint_reg,   setpoint_next;
    logic [SUM_W-1:0]   sum_reg,        sum_next;
    logic [SUM_W-1:0]   avg_reg,        avg_next;
    logic               heater_reg,     heater_next;
    logic               cooler_reg,     cooler_next;
    logic               led_phase_reg,  led_phase_next;
    logic               led_reg,        led_next;
    logic               setting_reg,    setting_next;
    logic [15:0]        press_ms_reg,   press_ms_next;
    logic [BLINK_W-1:0] blink_ms_reg,   blink_ms_next;
    logic               visible_reg,    visible_next;
    logic               save;

    logic [DEG_W-1:0]   deg;
    logic [SUM_W-1:0]   avg;
    logic [SUM_W:0]     sum_ext;
    logic [SUM_W:0]     avg_lo;
    logic [SUM_W:0]     avg_hi;
    logic [SP_W:0]      sp_up;
    logic [15:0]        press_inc;
    logic [BLINK_W-1:0] blink_inc;

    ath_arith u_arith
    (
        .reading (value[RD_W-1:0]),
        .sum     (sum_reg),
        .deg     (deg),
        .avg     (avg)
    );

    assign sum_ext   = {1'b0, sum_reg} + (SUM_W+1)'(deg);
    // avg <= sp - band and avg >= sp + band, kept unsigned
    assign avg_lo    = {1'b0, avg} + (SUM_W+1)'(cfg.band);
    assign avg_hi    = (SUM_W+1)'(setpoint_reg) + (SUM_W+1)'(cfg.band);
    assign sp_up     = {1'b0, setpoint_reg} + (SP_W+1)'(STEP);
    assign press_inc = (press_ms_reg == 16'hFFFF) ? press_ms_reg : press_ms_reg + 16'd1;
    assign blink_inc = blink_ms_reg + BLINK_W'(1);

    always_comb
    begin
        setpoint_next  = setpoint_reg;
        sum_next       = sum_reg;
        avg_next       = avg_reg;
        heater_next    = heater_reg;
        cooler_next    = cooler_reg;
        led_phase_next = led_phase_reg;
        led_next       = led_reg;
        setting_next   = setting_reg;
        press_ms_next  = press_ms_reg;
        blink_ms_next  = blink_ms_reg;
        visible_next   = visible_reg;
        save           = 1'b0;

        if (upd)
        begin
            unique case (func)
                FN_SAMPLE:
                begin
                    if (!setting_reg)
                    begin
                        sum_next = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
                    end
                end
                FN_CONTROL:
                begin
                    if (!setting_reg)
                    begin
                        avg_next = avg;
                        priority if (avg_lo <= (SUM_W+1)'(setpoint_reg))
                        begin
                            heater_next = 1'b1;
                            cooler_next = 1'b0;
                        end
                        else if ((SUM_W+1)'(avg) >= avg_hi)
                        begin
                            heater_next = 1'b0;
                            cooler_next = 1'b1;
                            led_next    = 1'b1;
                        end
                        else
                        begin
                            // inside the band the drives hold
                            heater_next = heater_reg;
                        end
                        if (heater_next)
                        begin
                            led_phase_next = !led_phase_reg;
                            led_next       = !led_phase_reg;
                        end
                        sum_next = '0;
                    end
                end
                FN_DOWN, FN_UP:
                begin
                    priority if (!setting_reg)
                    begin
                        setting_next  = 1'b1;
                        press_ms_next = '0;
                        blink_ms_next = '0;
                        visible_next  = 1'b1;
                        heater_next   = 1'b0;
                        cooler_next   = 1'b0;
                        led_next      = 1'b0;
                        sum_next      = '0;
                    end
                    else if (func == FN_DOWN)
                    begin
                        if (setpoint_reg > cfg.min_sp)
                        begin
                            setpoint_next = (setpoint_reg >= SP_W'(STEP))
                                          ? setpoint_reg - SP_W'(STEP) : '0;
                            press_ms_next = '0;
                        end
                    end
                    else
                    begin
                        if (setpoint_reg < cfg.max_sp)
                        begin
                            setpoint_next = sp_up[SP_W] ? {SP_W{1'b1}} : sp_up[SP_W-1:0];
                            press_ms_next = '0;
                        end
                    end
                end
                FN_MS_TICK:
                begin
                    if (setting_reg)
                    begin
                        press_ms_next = press_inc;
                        if (press_inc >= cfg.timeout)
                        begin
                            setting_next = 1'b0;
                            save         = 1'b1;
                        end
                        else if (blink_inc > BLINK_W'(BLINK_MS))
                        begin
                            blink_ms_next = '0;
                            visible_next  = !visible_reg;
                        end
                        else
                        begin
                            blink_ms_next = blink_inc;
                        end
                    end
                end
                FN_RESTORE:
                begin
                    setpoint_next = value[SP_W-1:0];
                end
                default:
                begin
                    save = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        res.heater_on      = heater_next;
        res.cooler_on      = cooler_next;
        res.led_on         = led_next;
        res.setting_active = setting_next;
        res.display_on     = setting_next && visible_next;
        res.setpoint       = setpoint_next;
        res.save_strobe    = save;
        res.average        = avg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= SETPOINT_RST;
            sum_reg       <= '0;
            avg_reg       <= '0;
            heater_reg    <= 1'b0;
            cooler_reg    <= 1'b0;
            led_phase_reg <= 1'b0;
            led_reg       <= 1'b0;
            setting_reg   <= 1'b0;
            press_ms_reg  <= '0;
            blink_ms_reg  <= '0;
            visible_reg   <= 1'b1;
        end
        else
        begin
            setpoint_reg  <= setpoint_next;
            sum_reg       <= sum_next;
            avg_reg       <= avg_next;
            heater_reg    <= heater_next;
            cooler_reg    <= cooler_next;
            led_phase_reg <= led_phase_next;
            led_reg       <= led_next;
            setting_reg   <= setting_next;
            press_ms_reg  <= press_ms_next;
            blink_ms_reg  <= blink_ms_next;
            visible_reg   <= visible_next;
        end
    end

`ifndef SYNTHESIS
    // heater and cooler never driven together
    a_no_heat_and_cool: assert property (@(posedge clk) disable iff (!rst_n)
        !(heater_reg && cooler_reg))
        else $error("heater and cooler both on");

    // drives stay off for the whole set mode
    a_quiet_in_setting: assert property (@(posedge clk) disable iff (!rst_n)
        setting_reg |-> (!heater_reg && !cooler_reg && !led_reg))
        else $error("drive active in set mode");

    // save strobe only when leaving set mode
    a_save_on_exit: assert property (@(posedge clk) disable iff (!rst_n)
        save |-> (setting_reg && !setting_next && upd && func == FN_MS_TICK))
        else $error("save strobe outside set mode exit");

    // blink counter wraps before passing its period
    a_blink_range: assert property (@(posedge clk) disable iff (!rst_n)
        blink_ms_reg <= BLINK_W'(BLINK_MS))
        else $error("blink counter out of range");
`endif

endmodule
